// ===== rtl/d96r_pkg.sv =====
// Shared types and constants for the 96-bit decimal round-to-integer block.
// No dependencies; imported by d96r_ctrl, d96r_datapath and the top level.
package d96r_pkg;

  localparam int DEF_MAX_SCALE = 28;
  localparam int SCALE_W       = 5;
  localparam int MAG_W         = 96;
  localparam int CHUNK_W       = 24;
  localparam int NUM_CHUNKS    = MAG_W / CHUNK_W;
  localparam int CHUNK_IDX_W   = $clog2(NUM_CHUNKS);
  localparam int DIGIT_W       = 4;
  localparam int PART_W        = CHUNK_W + DIGIT_W;

  // floor(n / 10) == (n * RECIP10) >> RECIP10_SHIFT for any n below 2**32
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;
  localparam int          PROD_W        = PART_W + 32;

  localparam logic [DIGIT_W-1:0] HALF_DIGIT = 4'd5;

  typedef enum logic [1:0] {
    ACT_TRUNC  = 2'd0,
    ACT_FLOOR  = 2'd1,
    ACT_ROUND  = 2'd2,
    ACT_NEGATE = 2'd3
  } action_t;

  typedef struct packed {
    logic                   load;
    logic                   step;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   finish;
  } d96r_cmd_t;

  typedef struct packed {
    logic               negate;
    logic [SCALE_W-1:0] scale;
  } d96r_status_t;

endpackage

// ===== rtl/decimal96_round_to_integer.sv =====
// 96-bit decimal round to integer: truncate, floor, round half away from zero, negate.
// Scale is clamped to MAX_SCALE; negate and zero scale skip the division and go straight to
// the final fixup. Each scale digit is divided out by the single 24-bit divide-by-ten unit
// walking the four chunks of the magnitude, top chunk first.
// A new item can be accepted in the cycle done is high. Sync reset clears controller and done.
// Depends on d96r_pkg, d96r_ctrl, d96r_datapath.
module decimal96_round_to_integer #(
  parameter int MAX_SCALE = d96r_pkg::DEF_MAX_SCALE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [63:0]                  magnitude_low,
  input  logic [31:0]                  magnitude_high,
  input  logic [d96r_pkg::SCALE_W-1:0] scale,
  input  logic                         negative,
  output logic                         done,
  output logic [63:0]                  result_magnitude_low,
  output logic [31:0]                  result_magnitude_high,
  output logic [d96r_pkg::SCALE_W-1:0] result_scale,
  output logic                         result_negative
);
  import d96r_pkg::*;

  d96r_cmd_t    cmd;
  d96r_status_t status;

  d96r_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  d96r_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .status                (status),
    .action                (action),
    .magnitude_low         (magnitude_low),
    .magnitude_high        (magnitude_high),
    .scale                 (scale),
    .negative              (negative),
    .result_magnitude_low  (result_magnitude_low),
    .result_magnitude_high (result_magnitude_high),
    .result_scale          (result_scale),
    .result_negative       (result_negative),
    .done                  (done)
  );

endmodule

// ===== rtl/d96r_ctrl.sv =====
// Controller: sequences load, per-digit chunk division steps and the final fixup.
// Depends on d96r_pkg.
module d96r_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  d96r_pkg::d96r_status_t status,
  output d96r_pkg::d96r_cmd_t    cmd
);
  import d96r_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t                 state;
  logic [SCALE_W-1:0]     digits;
  logic [CHUNK_IDX_W-1:0] chunk;

  always_comb begin
    cmd        = '0;
    cmd.load   = start && !busy;
    cmd.step   = (state == S_DIV);
    cmd.chunk  = chunk;
    cmd.finish = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      digits <= '0;
      chunk  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            state <= S_PREP;
            busy  <= 1'b1;
          end
        end
        S_PREP: begin
          digits <= status.scale;
          chunk  <= CHUNK_IDX_W'(NUM_CHUNKS - 1);
          if (status.negate || status.scale == '0) begin
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          chunk <= chunk - 1'b1;
          if (chunk == '0) begin
            // one full divide by ten done
            digits <= digits - 1'b1;
            if (digits == SCALE_W'(1)) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/d96r_datapath.sv =====
// Datapath: operand registers, 24-bit chunk divide-by-ten unit, increment and result registers.
// Depends on d96r_pkg.
module d96r_datapath #(
  parameter int MAX_SCALE = d96r_pkg::DEF_MAX_SCALE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  d96r_pkg::d96r_cmd_t          cmd,
  output d96r_pkg::d96r_status_t       status,
  input  logic [1:0]                   action,
  input  logic [63:0]                  magnitude_low,
  input  logic [31:0]                  magnitude_high,
  input  logic [d96r_pkg::SCALE_W-1:0] scale,
  input  logic                         negative,
  output logic [63:0]                  result_magnitude_low,
  output logic [31:0]                  result_magnitude_high,
  output logic [d96r_pkg::SCALE_W-1:0] result_scale,
  output logic                         result_negative,
  output logic                         done
);
  import d96r_pkg::*;

  logic [MAG_W-1:0]   mag;
  logic [DIGIT_W-1:0] rem;
  logic               sticky;
  action_t            act;
  logic               neg;
  logic [SCALE_W-1:0] scl;

  logic [SCALE_W-1:0] scale_clamped;
  logic [CHUNK_W-1:0] chunk_val;
  logic [DIGIT_W-1:0] rem_in;
  logic [PART_W-1:0]  part;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quot;
  logic [PART_W-1:0]  back;
  logic [DIGIT_W-1:0] rem_new;
  logic [MAG_W-1:0]   mag_step;
  logic               do_inc;
  logic [MAG_W-1:0]   mag_final;

  assign scale_clamped = (scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : scale;

  assign status.negate = (act == ACT_NEGATE);
  assign status.scale  = scl;

  // long division walks chunks from the top; remainder restarts at zero per digit
  assign chunk_val = mag[cmd.chunk*CHUNK_W +: CHUNK_W];
  assign rem_in    = (cmd.chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1)) ? '0 : rem;
  assign part      = {rem_in, chunk_val};
  assign prod      = PROD_W'(part) * PROD_W'(RECIP10);
  assign quot      = prod[RECIP10_SHIFT +: CHUNK_W];
  assign back      = (PART_W'(quot) << 3) + (PART_W'(quot) << 1);
  assign rem_new   = DIGIT_W'(part - back);

  always_comb begin
    mag_step = mag;
    mag_step[cmd.chunk*CHUNK_W +: CHUNK_W] = quot;
  end

  always_comb begin
    case (act)
      ACT_FLOOR: do_inc = neg && sticky;
      ACT_ROUND: do_inc = (scl != '0) && (rem >= HALF_DIGIT);
      default:   do_inc = 1'b0;
    endcase
  end

  assign mag_final = mag + MAG_W'(do_inc);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag    <= {magnitude_high, magnitude_low};
      rem    <= '0;
      sticky <= 1'b0;
      act    <= action_t'(action);
      neg    <= negative;
      scl    <= scale_clamped;
    end else if (cmd.step) begin
      mag <= mag_step;
      rem <= rem_new;
      if (cmd.chunk == '0 && rem_new != '0) begin
        sticky <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_magnitude_low  <= mag_final[63:0];
      result_magnitude_high <= mag_final[95:64];
      result_scale          <= (act == ACT_NEGATE) ? scl : '0;
      result_negative       <= neg ^ (act == ACT_NEGATE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule
